// File: design/sdas_pkg.sv
package sdas_pkg;

   localparam int SAMPLE_WIDTH = 12;
   localparam int ALPHA_WIDTH  = 9;
   localparam int BYTE_WIDTH   = 8;
   localparam int DIP_WIDTH    = 4;
   localparam int BUTTON_WIDTH = 5;
   localparam int CHANNELS     = 3;

   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = 9'd51;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [ALPHA_WIDTH-1:0]  alpha_type;
   typedef logic [BYTE_WIDTH-1:0]   byte_type;

endpackage

// File: design/sdas_debounce.sv
module sdas_debounce import sdas_pkg::*; #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [WIDTH-1:0] sample,
   output logic [WIDTH-1:0] held_next
);

   // Entry zero is the oldest sample.
   logic [WIDTH-1:0] hist_ff [DEPTH];
   logic [WIDTH-1:0] hist_in [DEPTH];
   logic [WIDTH-1:0] held_ff;
   logic             agree;

   always_comb begin
      agree = 1'b1;
      for (int i = 0; i < DEPTH - 1; i++) begin
         hist_in[i] = hist_ff[i + 1];
      end
      hist_in[DEPTH-1] = sample;
      // After the shift, the window agrees when every kept sample equals the new one.
      for (int i = 1; i < DEPTH; i++) begin
         if (hist_ff[i] != sample) begin
            agree = 1'b0;
         end
      end
      held_next = agree ? sample : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         held_ff <= '0;
      end else if (step) begin
         for (int i = 0; i < DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         held_ff <= held_next;
      end
   end

endmodule

// File: design/sdas_smooth.sv
module sdas_smooth import sdas_pkg::*; #(
   parameter int ADC_WIDTH = 12
) (
   input  logic       clock,
   input  logic       step,
   input  logic       primed,
   input  alpha_type  alpha,
   input  sample_type sample,
   output byte_type   byte_next
);

   localparam int DW = ADC_WIDTH + 1;
   localparam int PW = ADC_WIDTH + ALPHA_WIDTH + 2;
   localparam int QW = PW - 8;
   localparam int YW = QW + 1;
   localparam int HW = ADC_WIDTH + BYTE_WIDTH;

   logic [ADC_WIDTH-1:0]              value_ff;
   logic [ADC_WIDTH-1:0]              value_in;
   logic [SAMPLE_WIDTH+ADC_WIDTH-1:0] sample_wide;
   logic [ADC_WIDTH-1:0]              x;
   logic [ADC_WIDTH-1:0]              last;
   logic signed [DW-1:0]              diff;
   logic signed [PW-1:0]              prod;
   logic signed [QW-1:0]              quot;
   logic signed [YW-1:0]              y;
   logic [HW-1:0]                     high_wide;

   always_comb begin
      sample_wide = {{ADC_WIDTH{1'b0}}, sample};
      x           = sample_wide[ADC_WIDTH-1:0];
      // The first sample after reset seeds the filter.
      last        = primed ? value_ff : x;
      diff        = $signed({1'b0, x}) - $signed({1'b0, last});
      prod        = $signed({1'b0, alpha}) * diff;
      // Dropping the low byte of a two's complement value rounds toward minus infinity.
      quot        = $signed(prod[PW-1:8]);
      y           = $signed({{(YW-ADC_WIDTH){1'b0}}, last}) + $signed({quot[QW-1], quot});
      if (y[YW-1]) begin
         value_in = '0;
      end else if (|y[YW-2:ADC_WIDTH]) begin
         value_in = '1;
      end else begin
         value_in = y[ADC_WIDTH-1:0];
      end
      high_wide = {{BYTE_WIDTH{1'b0}}, value_in} >> 4;
      byte_next = (|high_wide[HW-1:BYTE_WIDTH]) ? '1 : high_wide[BYTE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
      end
   end

endmodule

// File: design/switch_debounce_and_adc_smoothing.sv
// Debounces a DIP switch group and a push button group and smooths three converter
// channels with a first-order low-pass filter, one result per request. A request is
// taken into an input register; the filters and debouncers then update from it into
// the result register, so the block accepts one request every clock cycle unless a
// result stalls; a result is registered once its held request moves on. A stalled
// result holds the input register, and the request side stalls once that is full.
// A switch group's state follows its input only after AGREE_SAMPLES equal samples.
// Each filter computes last + floor(alpha * (x - last) / 256), seeded by the first
// sample after reset and clamped to ADC_WIDTH bits; alpha comes from the csr register
// (reset value 51, about 0.2). Results carry the filtered values divided by 16,
// saturated at 255, with channel 1 (joystick x) ahead of channel 0 (joystick y).
module switch_debounce_and_adc_smoothing import sdas_pkg::*; #(
   parameter int ADC_WIDTH     = 12,
   parameter int AGREE_SAMPLES = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  alpha_type               csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [DIP_WIDTH-1:0]    req_dip_bits,
   input  logic [BUTTON_WIDTH-1:0] req_button_bits,
   input  sample_type              req_adc_ch0,
   input  sample_type              req_adc_ch1,
   input  sample_type              req_adc_ch2,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [DIP_WIDTH-1:0]    rsp_dip_state,
   output byte_type                rsp_joy_x_byte,
   output byte_type                rsp_joy_y_byte,
   output byte_type                rsp_pot_byte,
   output logic [BUTTON_WIDTH-1:0] rsp_button_state
);

   alpha_type               alpha_ff;
   logic                    primed_ff;
   logic                    in_valid_ff;
   logic [DIP_WIDTH-1:0]    dip_ff;
   logic [BUTTON_WIDTH-1:0] button_ff;
   sample_type              chan_ff [CHANNELS];
   byte_type                byte_next [CHANNELS];
   logic [DIP_WIDTH-1:0]    dip_next;
   logic [BUTTON_WIDTH-1:0] button_next;
   logic                    advance;
   logic                    req_take;

   logic                    rsp_valid_ff;
   logic [DIP_WIDTH-1:0]    rsp_dip_ff;
   byte_type                rsp_joy_x_ff;
   byte_type                rsp_joy_y_ff;
   byte_type                rsp_pot_ff;
   logic [BUTTON_WIDTH-1:0] rsp_button_ff;

   // The held request moves on whenever the result register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_write_enable) begin
         alpha_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         dip_ff     <= req_dip_bits;
         button_ff  <= req_button_bits;
         chan_ff[0] <= req_adc_ch0;
         chan_ff[1] <= req_adc_ch1;
         chan_ff[2] <= req_adc_ch2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else if (advance) begin
         primed_ff <= 1'b1;
      end
   end

   sdas_debounce #(
      .WIDTH (DIP_WIDTH),
      .DEPTH (AGREE_SAMPLES)
   ) u_dip_debounce (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .sample    (dip_ff),
      .held_next (dip_next)
   );

   sdas_debounce #(
      .WIDTH (BUTTON_WIDTH),
      .DEPTH (AGREE_SAMPLES)
   ) u_button_debounce (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .sample    (button_ff),
      .held_next (button_next)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      sdas_smooth #(
         .ADC_WIDTH (ADC_WIDTH)
      ) u_smooth (
         .clock     (clock),
         .step      (advance),
         .primed    (primed_ff),
         .alpha     (alpha_ff),
         .sample    (chan_ff[c]),
         .byte_next (byte_next[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_dip_ff    <= dip_next;
         rsp_joy_x_ff  <= byte_next[1];
         rsp_joy_y_ff  <= byte_next[0];
         rsp_pot_ff    <= byte_next[2];
         rsp_button_ff <= button_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dip_state    = rsp_dip_ff;
   assign rsp_joy_x_byte   = rsp_joy_x_ff;
   assign rsp_joy_y_byte   = rsp_joy_y_ff;
   assign rsp_pot_byte     = rsp_pot_ff;
   assign rsp_button_state = rsp_button_ff;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sdas_pkg::*;

   localparam int AGREE_DEPTH = 3;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS = 54;
   localparam longint SAMPLE_MAX = (longint'(1) << SAMPLE_WIDTH) - 1;

   typedef logic [DIP_WIDTH-1:0]    dip_type;
   typedef logic [BUTTON_WIDTH-1:0] button_type;

   typedef struct packed {
      dip_type    dip_state;
      byte_type   joy_x_byte;
      byte_type   joy_y_byte;
      byte_type   pot_byte;
      button_type button_state;
   } tick_result_t;

   typedef struct {
      int           new_alpha;
      dip_type      dip;
      button_type   buttons;
      sample_type   ch0;
      sample_type   ch1;
      sample_type   ch2;
      bit           typed;
      tick_result_t typed_res;
   } directed_row_t;

   typedef struct {
      bit           typed;
      tick_result_t res;
   } typed_answer_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   alpha_type  csr_write_data = ALPHA_RESET;
   logic       req_valid = 1'b0;
   logic       req_stall;
   dip_type    req_dip_bits = '0;
   button_type req_button_bits = '0;
   sample_type req_adc_ch0 = '0;
   sample_type req_adc_ch1 = '0;
   sample_type req_adc_ch2 = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   dip_type    rsp_dip_state;
   byte_type   rsp_joy_x_byte;
   byte_type   rsp_joy_y_byte;
   byte_type   rsp_pot_byte;
   button_type rsp_button_state;

   // A new_alpha of -1 leaves the weight as it is; typed rows carry their own answer.
   directed_row_t directed_rows [16] = '{
      '{ -1, 4'h0, 5'h00, 12'hFFF, 12'h000, 12'h800, 1'b1,
         '{4'h0, 8'h00, 8'hFF, 8'h80, 5'h00}},
      '{ -1, 4'h1, 5'h01, 12'h000, 12'hFFF, 12'h123, 1'b0, '0},
      '{ -1, 4'hF, 5'h1F, 12'hFFF, 12'h000, 12'hFFF, 1'b0, '0},
      '{ -1, 4'hF, 5'h1F, 12'h7FF, 12'h800, 12'h001, 1'b0, '0},
      '{256, 4'hF, 5'h1F, 12'hFFF, 12'h010, 12'h0F0, 1'b1,
         '{4'hF, 8'h01, 8'hFF, 8'h0F, 5'h1F}},
      '{ -1, 4'hA, 5'h15, 12'h000, 12'hFFF, 12'h7FF, 1'b1,
         '{4'hF, 8'hFF, 8'h00, 8'h7F, 5'h1F}},
      '{ -1, 4'hA, 5'h15, 12'h100, 12'h200, 12'h300, 1'b1,
         '{4'hF, 8'h20, 8'h10, 8'h30, 5'h1F}},
      '{ -1, 4'hA, 5'h15, 12'hC00, 12'h456, 12'h00F, 1'b1,
         '{4'hA, 8'h45, 8'hC0, 8'h00, 5'h15}},
      '{511, 4'h5, 5'h0A, 12'hFFF, 12'h000, 12'h800, 1'b0, '0},
      '{ -1, 4'h5, 5'h0A, 12'h000, 12'hFFF, 12'h000, 1'b0, '0},
      '{  0, 4'h5, 5'h0A, 12'h555, 12'hAAA, 12'h555, 1'b0, '0},
      '{ -1, 4'h0, 5'h00, 12'hAAA, 12'h555, 12'hAAA, 1'b0, '0},
      '{  1, 4'h0, 5'h00, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, '0},
      '{255, 4'h0, 5'h00, 12'h000, 12'h000, 12'h000, 1'b0, '0},
      '{ 51, 4'h9, 5'h11, 12'h001, 12'hFFE, 12'h7FF, 1'b0, '0},
      '{ -1, 4'h6, 5'h0E, 12'hFFE, 12'h001, 12'h800, 1'b0, '0}
   };

   // Predictor state.
   dip_type    dip_hist [AGREE_DEPTH];
   button_type button_hist [AGREE_DEPTH];
   dip_type    held_dip;
   button_type held_buttons;
   bit         primed;
   sample_type level [CHANNELS];
   alpha_type  weight;

   tick_result_t  pending_results [$];
   typed_answer_t typed_answers [$];
   int error_count = 0;
   int request_count = 0;
   int result_count = 0;
   int weight_writes = 0;
   int hold_requests = 0;
   int snd_idle_pct = 0;
   int rsp_idle_pct = 0;
   dip_type    cur_dip = '0;
   button_type cur_buttons = '0;
   sample_type last_ch [CHANNELS] = '{default: '0};

   switch_debounce_and_adc_smoothing dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_dip_bits     (req_dip_bits),
      .req_button_bits  (req_button_bits),
      .req_adc_ch0      (req_adc_ch0),
      .req_adc_ch1      (req_adc_ch1),
      .req_adc_ch2      (req_adc_ch2),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dip_state    (rsp_dip_state),
      .rsp_joy_x_byte   (rsp_joy_x_byte),
      .rsp_joy_y_byte   (rsp_joy_y_byte),
      .rsp_pot_byte     (rsp_pot_byte),
      .rsp_button_state (rsp_button_state)
   );

   always #1 clock = ~clock;

   function automatic void clear_prediction();
      for (int i = 0; i < AGREE_DEPTH; i++) begin
         dip_hist[i] = '0;
         button_hist[i] = '0;
      end
      held_dip = '0;
      held_buttons = '0;
      primed = 1'b0;
      for (int c = 0; c < CHANNELS; c++) level[c] = '0;
      weight = ALPHA_RESET;
   endfunction

   function automatic sample_type low_pass(sample_type last, sample_type x);
      longint prod;
      longint y;
      prod = longint'(weight) * (longint'(x) - longint'(last));
      // Arithmetic shift gives the floor for negative differences too.
      y = longint'(last) + (prod >>> 8);
      if (y < 0) y = 0;
      else if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      return sample_type'(y);
   endfunction

   function automatic tick_result_t predict_tick(dip_type dip, button_type buttons,
                                                 sample_type ch0, sample_type ch1,
                                                 sample_type ch2);
      sample_type   x [CHANNELS];
      bit           dip_same;
      bit           buttons_same;
      tick_result_t r;
      x[0] = ch0;
      x[1] = ch1;
      x[2] = ch2;
      for (int i = 0; i < AGREE_DEPTH - 1; i++) begin
         dip_hist[i] = dip_hist[i+1];
         button_hist[i] = button_hist[i+1];
      end
      dip_hist[AGREE_DEPTH-1] = dip;
      button_hist[AGREE_DEPTH-1] = buttons;
      dip_same = 1'b1;
      buttons_same = 1'b1;
      for (int i = 0; i < AGREE_DEPTH - 1; i++) begin
         if (dip_hist[i] != dip_hist[i+1]) dip_same = 1'b0;
         if (button_hist[i] != button_hist[i+1]) buttons_same = 1'b0;
      end
      if (dip_same) held_dip = dip;
      if (buttons_same) held_buttons = buttons;
      if (!primed) begin
         primed = 1'b1;
         for (int c = 0; c < CHANNELS; c++) level[c] = x[c];
      end
      for (int c = 0; c < CHANNELS; c++) level[c] = low_pass(level[c], x[c]);
      r.dip_state = held_dip;
      r.joy_x_byte = byte_type'(level[1] >> 4);
      r.joy_y_byte = byte_type'(level[0] >> 4);
      r.pot_byte = byte_type'(level[2] >> 4);
      r.button_state = held_buttons;
      return r;
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      tick_result_t  predicted;
      tick_result_t  want;
      typed_answer_t answer;
      if (reset) begin
         clear_prediction();
      end else begin
         if (csr_write_enable) weight = csr_write_data;
         if (req_valid && !req_stall) begin
            predicted = predict_tick(req_dip_bits, req_button_bits,
                                     req_adc_ch0, req_adc_ch1, req_adc_ch2);
            answer.typed = 1'b0;
            if (typed_answers.size() != 0) answer = typed_answers.pop_front();
            pending_results.push_back(answer.typed ? answer.res : predicted);
            request_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: result with no request waiting, expected none, got %h %h %h %h %h",
                        $time, rsp_dip_state, rsp_joy_x_byte, rsp_joy_y_byte,
                        rsp_pot_byte, rsp_button_state);
            end else begin
               want = pending_results.pop_front();
               check_field("dip_state", 8'(want.dip_state), 8'(rsp_dip_state));
               check_field("joy_x_byte", want.joy_x_byte, rsp_joy_x_byte);
               check_field("joy_y_byte", want.joy_y_byte, rsp_joy_y_byte);
               check_field("pot_byte", want.pot_byte, rsp_pot_byte);
               check_field("button_state", 8'(want.button_state), 8'(rsp_button_state));
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold whenever the stimulus asks for one.
   initial begin
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   task automatic offer_request(dip_type dip, button_type buttons, sample_type ch0,
                                sample_type ch1, sample_type ch2, bit typed,
                                tick_result_t typed_res);
      typed_answer_t answer;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      answer.typed = typed;
      answer.res = typed_res;
      typed_answers.push_back(answer);
      req_valid <= 1'b1;
      req_dip_bits <= dip;
      req_button_bits <= buttons;
      req_adc_ch0 <= ch0;
      req_adc_ch1 <= ch1;
      req_adc_ch2 <= ch2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_weight(alpha_type value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      weight_writes++;
   endtask

   // Switch bits mostly hold for a few ticks so the debouncers see agreement;
   // one request in ten is pure noise.
   task automatic send_random_request();
      sample_type ch [CHANNELS];
      if ($urandom_range(9) == 0) begin
         cur_dip = dip_type'($urandom_range(15));
         cur_buttons = button_type'($urandom_range(31));
      end else begin
         if ($urandom_range(9) < 2) cur_dip = dip_type'($urandom_range(15));
         if ($urandom_range(9) < 2) cur_buttons = button_type'($urandom_range(31));
      end
      for (int c = 0; c < CHANNELS; c++) begin
         case ($urandom_range(5))
            0: ch[c] = '0;
            1: ch[c] = '1;
            2, 3: ch[c] = sample_type'($urandom_range(4095));
            default: ch[c] = last_ch[c] + sample_type'($urandom_range(64)) - sample_type'(32);
         endcase
         last_ch[c] = ch[c];
      end
      offer_request(cur_dip, cur_buttons, ch[0], ch[1], ch[2], 1'b0, '0);
   endtask

   initial begin
      int alpha_plan [12];
      int plan;
      alpha_plan = '{0, 511, 256, -1, 1, 255, 51, -1, 128, 2, 510, -1};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].new_alpha >= 0)
            set_weight(alpha_type'(directed_rows[i].new_alpha));
         offer_request(directed_rows[i].dip, directed_rows[i].buttons,
                       directed_rows[i].ch0, directed_rows[i].ch1, directed_rows[i].ch2,
                       directed_rows[i].typed, directed_rows[i].typed_res);
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               snd_idle_pct = 9;
               rsp_idle_pct = 86;
            end
            1: begin
               snd_idle_pct = 86;
               rsp_idle_pct = 9;
            end
            default: begin
               snd_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int p = 0; p < 4; p++) begin
            plan = alpha_plan[mode*4 + p];
            set_weight(plan < 0 ? alpha_type'($urandom_range(511)) : alpha_type'(plan));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
               // Stop taking results for a while so the block backs up into its input.
               if (p == 1 && n == 10) hold_requests++;
               send_random_request();
            end
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Run covered %0d requests and %0d results across %0d filter weight writes,",
               request_count, result_count, weight_writes);
      $display("including %0d long result holds and weights from 0 to 511.", hold_requests);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Timed out with %0d results still expected.", pending_results.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
